>>> rtl/fcd_pkg.sv
// ----------------------------------------------------------------------------
// fcd_pkg
// Shared constants, types and functions for the 5x5 fiducial code decoder.
// ----------------------------------------------------------------------------
package fcd_pkg;

  localparam int GRID_N    = 5;
  localparam int CELL_N    = GRID_N * GRID_N;
  localparam int ROT_N     = 4;
  localparam int CODE_N    = 4;
  localparam int ID_W      = 10;
  localparam int DIST_W    = 4;
  localparam int ROW_DIST_W = 3;
  localparam int ROT_W     = 2;

  localparam logic [DIST_W-1:0] MaxErrorsReset = 4'd2;
  localparam logic [DIST_W-1:0] MaxDistance    = 4'd10;

  // Row codewords, cell x at bit x.
  localparam logic [GRID_N-1:0] Codewords [CODE_N] = '{
    5'h01, 5'h1D, 5'h12, 5'h0E
  };

  typedef logic [CELL_N-1:0] grid_t;

  // Per-rotation score handed from the evaluator to the selector.
  typedef struct packed {
    logic [DIST_W-1:0] score;
    logic [ID_W-1:0]   id;
  } rot_eval_t;

  // Rotated cell (x,y) is read from input cell:
  // 0 (x,y); 1 (4-y,x); 2 (4-x,4-y); 3 (y,4-x).
  function automatic grid_t rotate_grid(grid_t grid, logic [ROT_W-1:0] rot);
    grid_t res;
    int    src;
    res = '0;
    for (int y = 0; y < GRID_N; y++) begin
      for (int x = 0; x < GRID_N; x++) begin
        unique case (rot)
          2'd1:    src = x * GRID_N + (GRID_N - 1 - y);
          2'd2:    src = (GRID_N - 1 - y) * GRID_N + (GRID_N - 1 - x);
          2'd3:    src = (GRID_N - 1 - x) * GRID_N + y;
          default: src = y * GRID_N + x;
        endcase
        res[y*GRID_N+x] = grid[src];
      end
    end
    return res;
  endfunction

  // Smallest Hamming distance of a row to any codeword.
  function automatic logic [ROW_DIST_W-1:0] row_distance(logic [GRID_N-1:0] row);
    logic [ROW_DIST_W-1:0] best;
    logic [ROW_DIST_W-1:0] d;
    logic [GRID_N-1:0]     diff;
    best = ROW_DIST_W'(GRID_N);
    for (int p = 0; p < CODE_N; p++) begin
      diff = row ^ Codewords[p];
      d    = '0;
      for (int i = 0; i < GRID_N; i++) begin
        d = d + ROW_DIST_W'(diff[i]);
      end
      if (d < best) begin
        best = d;
      end
    end
    return best;
  endfunction

endpackage

>>> rtl/fcd_rot_eval.sv
// ----------------------------------------------------------------------------
// fcd_rot_eval
// Scores one rotated grid: summed row distance and the candidate id.
// ----------------------------------------------------------------------------
module fcd_rot_eval import fcd_pkg::*; (
  input  grid_t     grid_i,
  output rot_eval_t eval_o
);

  logic [DIST_W-1:0] sum;
  logic [ID_W-1:0]   id;

  always_comb begin
    sum = '0;
    id  = '0;
    for (int y = 0; y < GRID_N; y++) begin
      sum = sum + DIST_W'(row_distance(grid_i[y*GRID_N +: GRID_N]));
      // cells 1 and 3 of each row, first row in the top bits
      id[ID_W-1-2*y] = grid_i[y*GRID_N + 1];
      id[ID_W-2-2*y] = grid_i[y*GRID_N + 3];
    end
  end

  assign eval_o.score = sum;
  assign eval_o.id    = id;

endmodule

>>> rtl/fiducial_code_decode.sv
// ----------------------------------------------------------------------------
// fiducial_code_decode
// Decodes a 5x5 binary fiducial grid: best of four rotations by row Hamming
// distance to the code alphabet, then id extraction and limit check.
// ----------------------------------------------------------------------------
// One grid is taken in every clock cycle: busy_o stays low, so start_i may be
// held high for a continuous stream. Each accepted grid gives exactly one
// result: the grid enters the input register at the accepting edge and the
// result register at the next edge, so a one-cycle done_o pulse follows in
// the cycle right after that. The receiver cannot stall: capture the result
// ports whenever done_o is high. The error limit is written through cfg_we_i /
// cfg_wdata_i (reset value 2); write it only while no grid is in flight.
// When found_o is low, marker_id_o and rotation_o read as zero while
// best_distance_o still reports the smallest summed distance.
// ----------------------------------------------------------------------------
module fiducial_code_decode import fcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command side
  input  logic              start_i,
  output logic              busy_o,
  input  logic [CELL_N-1:0] cell_bits_i,
  // error limit register
  input  logic              cfg_we_i,
  input  logic [DIST_W-1:0] cfg_wdata_i,
  // result side
  output logic              done_o,
  output logic              found_o,
  output logic [ID_W-1:0]   marker_id_o,
  output logic [ROT_W-1:0]  rotation_o,
  output logic [DIST_W-1:0] best_distance_o
);

  logic              accept;
  logic [DIST_W-1:0] max_errors_q;

  // input register
  logic              in_valid_q;
  grid_t             grid_q;

  // per-rotation scores
  rot_eval_t         eval [ROT_N];

  // selection
  logic [DIST_W-1:0] best_dist;
  logic [ROT_W-1:0]  best_rot;
  logic [ID_W-1:0]   best_id;
  logic              found;

  // result register
  logic              done_q;
  logic              found_q;
  logic [ID_W-1:0]   id_q;
  logic [ROT_W-1:0]  rot_q;
  logic [DIST_W-1:0] dist_q;

  // Never back-pressure: the datapath takes a word every cycle.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_errors_q <= MaxErrorsReset;
    end else if (cfg_we_i) begin
      max_errors_q <= cfg_wdata_i;
    end
  end

  // Capture the grid; only the valid flag needs reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      grid_q <= cell_bits_i;
    end
  end

  // Score all four rotations in parallel.
  for (genvar r = 0; r < ROT_N; r++) begin : g_rot
    fcd_rot_eval u_eval (
      .grid_i (rotate_grid(grid_q, ROT_W'(r))),
      .eval_o (eval[r])
    );
  end

  // Strictly lower sum wins, so the earliest rotation keeps a tie.
  always_comb begin
    best_dist = eval[0].score;
    best_rot  = '0;
    best_id   = eval[0].id;
    for (int r = 1; r < ROT_N; r++) begin
      if (eval[r].score < best_dist) begin
        best_dist = eval[r].score;
        best_rot  = ROT_W'(r);
        best_id   = eval[r].id;
      end
    end
    found = (best_dist <= max_errors_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  // Drop id and rotation when the grid misses the limit.
  always_ff @(posedge clk_i) begin
    if (in_valid_q) begin
      found_q <= found;
      id_q    <= found ? best_id  : '0;
      rot_q   <= found ? best_rot : '0;
      dist_q  <= best_dist;
    end
  end

  assign done_o          = done_q;
  assign found_o         = found_q;
  assign marker_id_o     = id_q;
  assign rotation_o      = rot_q;
  assign best_distance_o = dist_q;

`ifndef ASSERT_OFF
  // every captured grid produces exactly one result the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (done_o == $past(in_valid_q)))
    else $error("result strobe does not follow the input register");

  // a miss reports no id and no rotation
  a_miss_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !found_o) |-> (marker_id_o == '0 && rotation_o == '0))
    else $error("id or rotation nonzero on a miss");

  // five rows at most two apart from the alphabet each
  a_dist_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (best_distance_o <= MaxDistance))
    else $error("summed distance out of range");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fiducial_code_decode. Grids go in through the
// start/busy command port, both hand-built markers (any id, any rotation,
// up to ten flipped cells) and raw random grids. Each word is decoded by a
// behavioral model at the moment it is accepted. The expected result is
// queued there and compared field by field with every done_o strobe. The
// error limit is rewritten between phases while nothing is in flight.
// ----------------------------------------------------------------------------
module testbench;
  import fcd_pkg::*;

  typedef struct packed {
    logic              found;
    logic [ID_W-1:0]   code_id;
    logic [ROT_W-1:0]  rotation;
    logic [DIST_W-1:0] best_distance;
  } decode_t;

  // Row alphabet, cell x at bit x. The entry index equals the id bit pair
  // {cell 1, cell 3} that the row carries.
  localparam logic [GRID_N-1:0] ROW_CODES [4] = '{5'h01, 5'h1D, 5'h12, 5'h0E};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [CELL_N-1:0] cell_bits_i;
  logic              cfg_we_i;
  logic [DIST_W-1:0] cfg_wdata_i;
  logic              done_o;
  logic              found_o;
  logic [ID_W-1:0]   marker_id_o;
  logic [ROT_W-1:0]  rotation_o;
  logic [DIST_W-1:0] best_distance_o;

  decode_t           pending_decodes[$];
  logic [DIST_W-1:0] err_limit;
  int                failures;
  int                grids_checked;
  int                markers_found;
  int                limit_writes;

  fiducial_code_decode dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cell_bits_i     (cell_bits_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .found_o         (found_o),
    .marker_id_o     (marker_id_o),
    .rotation_o      (rotation_o),
    .best_distance_o (best_distance_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Input cell that lands at rotated position (x,y).
  function automatic int source_cell(int rot, int x, int y);
    case (rot)
      1:       return x * GRID_N + (GRID_N - 1 - y);
      2:       return (GRID_N - 1 - y) * GRID_N + (GRID_N - 1 - x);
      3:       return (GRID_N - 1 - x) * GRID_N + y;
      default: return y * GRID_N + x;
    endcase
  endfunction

  // Behavioral decode: score all four rotations, keep the first strict
  // minimum, then apply the error limit.
  function automatic decode_t decode_grid(logic [CELL_N-1:0] grid, logic [DIST_W-1:0] limit);
    decode_t         res;
    int              sum;
    int              best_sum;
    int              best_rot;
    int              row_dist;
    int              d;
    logic [GRID_N-1:0] row;
    logic [ID_W-1:0] id;
    logic [ID_W-1:0] best_id;
    best_sum = 1000;
    best_rot = 0;
    best_id  = '0;
    for (int r = 0; r < ROT_N; r++) begin
      sum = 0;
      id  = '0;
      for (int y = 0; y < GRID_N; y++) begin
        for (int x = 0; x < GRID_N; x++) begin
          row[x] = grid[source_cell(r, x, y)];
        end
        row_dist = GRID_N;
        for (int p = 0; p < 4; p++) begin
          d = $countones(row ^ ROW_CODES[p]);
          if (d < row_dist) begin
            row_dist = d;
          end
        end
        sum += row_dist;
        id = {id[ID_W-3:0], row[1], row[3]};
      end
      if (sum < best_sum) begin
        best_sum = sum;
        best_rot = r;
        best_id  = id;
      end
    end
    res.found         = (best_sum <= int'(limit));
    res.code_id       = res.found ? best_id : '0;
    res.rotation      = res.found ? ROT_W'(best_rot) : '0;
    res.best_distance = DIST_W'(best_sum);
    return res;
  endfunction

  // Build a clean marker that decodes as 'id' under rotation 'rot'.
  function automatic logic [CELL_N-1:0] make_marker(logic [ID_W-1:0] id, int rot);
    logic [CELL_N-1:0] canon;
    logic [CELL_N-1:0] grid;
    for (int y = 0; y < GRID_N; y++) begin
      canon[y*GRID_N +: GRID_N] = ROW_CODES[id[ID_W-1-2*y -: 2]];
    end
    for (int y = 0; y < GRID_N; y++) begin
      for (int x = 0; x < GRID_N; x++) begin
        grid[source_cell(rot, x, y)] = canon[y*GRID_N+x];
      end
    end
    return grid;
  endfunction

  function automatic logic [CELL_N-1:0] flip_cells(logic [CELL_N-1:0] grid, int count);
    for (int i = 0; i < count; i++) begin
      grid[$urandom_range(0, CELL_N-1)] ^= 1'b1;
    end
    return grid;
  endfunction

  // Queue the expected decode for every word the block takes.
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) begin
      pending_decodes.insert(pending_decodes.size(), decode_grid(cell_bits_i, err_limit));
    end
  end

  // Compare every strobed result against the oldest expectation.
  always @(posedge clk_i) begin
    decode_t want;
    if (rst_ni && done_o) begin
      if (pending_decodes.size() == 0) begin
        $error("unexpected result: found %0d id %0d rot %0d dist %0d",
               found_o, marker_id_o, rotation_o, best_distance_o);
        failures++;
      end else begin
        want = pending_decodes.pop_front();
        grids_checked++;
        if (found_o) begin
          markers_found++;
        end
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          failures++;
        end
        if (marker_id_o !== want.code_id) begin
          $error("marker id: expected %0d, got %0d", want.code_id, marker_id_o);
          failures++;
        end
        if (rotation_o !== want.rotation) begin
          $error("rotation: expected %0d, got %0d", want.rotation, rotation_o);
          failures++;
        end
        if (best_distance_o !== want.best_distance) begin
          $error("best_distance: expected %0d, got %0d",
                 want.best_distance, best_distance_o);
          failures++;
        end
      end
    end
  end

  // Present one grid and hold it until the block takes it. Leave start high
  // so a following word can go out back to back.
  task automatic send_grid(logic [CELL_N-1:0] grid);
    start_i     <= 1'b1;
    cell_bits_i <= grid;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start for a random burst and drive random values on the idle data lines.
  task automatic idle_burst();
    start_i     <= 1'b0;
    cell_bits_i <= CELL_N'($urandom);
    repeat ($urandom_range(1, 8)) @(posedge clk_i);
  endtask

  task automatic send_maybe_idle(logic [CELL_N-1:0] grid);
    send_grid(grid);
    if ($urandom_range(0, 2) == 0) begin
      idle_burst();
    end
  endtask

  // Drain the pipeline, then write the error limit.
  task automatic set_limit(logic [DIST_W-1:0] value);
    start_i <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    err_limit = value;
    limit_writes++;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= DIST_W'($urandom);
  endtask

  // Reset limit of two: blank and saturated grids, lone corner cells, clean
  // markers in every rotation, and markers just inside and outside the limit.
  task automatic test_default_limit();
    logic [CELL_N-1:0] base;
    send_maybe_idle('0);
    send_maybe_idle('1);
    send_maybe_idle(25'h1555555);
    send_maybe_idle(25'h0AAAAAA);
    send_maybe_idle(25'h0000001);
    send_maybe_idle(25'h1000000);
    send_maybe_idle(make_marker(10'h000, 0));
    send_maybe_idle(make_marker(10'h3FF, 0));
    for (int r = 0; r < ROT_N; r++) begin
      send_maybe_idle(make_marker(10'h2C5, r));
    end
    base = make_marker(10'h13A, 1);
    send_maybe_idle(base ^ 25'h0000001);
    send_maybe_idle(base ^ 25'h1000001);
    send_maybe_idle(base ^ 25'h1001001);
  endtask

  // Both ends of the limit range, and a limit above ten that accepts anything.
  task automatic test_limit_extremes();
    set_limit(4'd0);
    send_maybe_idle(make_marker(10'h0F0, 2));
    send_maybe_idle(make_marker(10'h0F0, 2) ^ 25'h0000400);
    set_limit(4'd10);
    send_maybe_idle('1);
    send_maybe_idle(25'h0AAAAAA);
    send_maybe_idle(CELL_N'($urandom));
    set_limit(4'd15);
    send_maybe_idle('0);
    send_maybe_idle(25'h1555555);
    send_maybe_idle(CELL_N'($urandom));
  endtask

  // Mostly damaged markers with random id and rotation, the rest raw noise.
  task automatic test_random_mix(int count, bit allow_idle);
    logic [CELL_N-1:0] grid;
    int                flips;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        flips = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
        grid  = flip_cells(make_marker(ID_W'($urandom), $urandom_range(0, 3)), flips);
      end else begin
        grid = CELL_N'($urandom);
      end
      if (allow_idle && (i % 40) < 25) begin
        send_maybe_idle(grid);
      end else begin
        send_grid(grid);
      end
    end
  endtask

  // Run time ceiling.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    start_i       <= 1'b0;
    cell_bits_i   <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    err_limit     = MaxErrorsReset;
    failures      = 0;
    grids_checked = 0;
    markers_found = 0;
    limit_writes  = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_limit();
    test_limit_extremes();
    for (int phase = 0; phase < 5; phase++) begin
      set_limit(DIST_W'($urandom_range(0, 10)));
      test_random_mix(100, 1'b1);
    end
    // Closing stretch: a continuous stream with no gaps.
    set_limit(4'd2);
    test_random_mix(100, 1'b0);
    start_i <= 1'b0;

    while (pending_decodes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (pending_decodes.size() != 0) begin
      $error("%0d results never arrived", pending_decodes.size());
      failures++;
    end

    $display("Decoded %0d grids, %0d reported as markers, over %0d limit writes.",
             grids_checked, markers_found, limit_writes);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/fcd_pkg.sv
rtl/fcd_rot_eval.sv
rtl/fiducial_code_decode.sv
tb/testbench.sv
